// ===== src/sbam_pkg.sv =====
// Shared types and constants for the signed ALU with multiply and divide.
`timescale 1ns / 1ps

package sbam_pkg;

  localparam int FUNC_W    = 3;
  localparam int DEF_WIDTH = 8;

  typedef enum logic [FUNC_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } op_t;

  // Per-beat control carried down the cell row.
  typedef struct packed {
    op_t  op;
    logic neg_a;
    logic neg_b;
    logic ovf;     // add/sub overflow, found at the front
  } ctl_t;

endpackage

// ===== src/sbam_prep.sv =====
// Front stage: operand magnitudes, add/sub, and accumulator seed.
`timescale 1ns / 1ps

module sbam_prep import sbam_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [WIDTH-1:0]     a_i,
  input  logic [WIDTH-1:0]     b_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output ctl_t                 ctl_o,
  output logic [WIDTH-1:0]     ma_o,
  output logic [WIDTH-1:0]     mb_o,
  output logic [2*WIDTH-1:0]   acc_o,
  input  logic                 ready_i
);

  logic               valid_r, valid_nxt;
  logic               take;
  ctl_t               ctl_r, ctl_nxt;
  logic [WIDTH-1:0]   ma_r, mb_r, ma_nxt, mb_nxt;
  logic [2*WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH:0]     sum, diff;

  assign ready_o   = !valid_r || ready_i;
  assign take      = valid_i && ready_o;
  assign valid_nxt = take || (valid_r && !ready_i);

  always_comb begin
    ctl_nxt.op    = op_t'(func_i);
    ctl_nxt.neg_a = a_i[WIDTH-1];
    ctl_nxt.neg_b = b_i[WIDTH-1];
    ctl_nxt.ovf   = 1'b0;
    ma_nxt = a_i[WIDTH-1] ? -a_i : a_i;
    mb_nxt = b_i[WIDTH-1] ? -b_i : b_i;
    sum    = {a_i[WIDTH-1], a_i} + {b_i[WIDTH-1], b_i};
    diff   = {a_i[WIDTH-1], a_i} - {b_i[WIDTH-1], b_i};
    acc_nxt = '0;
    case (ctl_nxt.op)
      OP_ADD: begin
        acc_nxt     = {{WIDTH{1'b0}}, sum[WIDTH-1:0]};
        ctl_nxt.ovf = sum[WIDTH] ^ sum[WIDTH-1];
      end
      OP_SUB: begin
        acc_nxt     = {{WIDTH{1'b0}}, diff[WIDTH-1:0]};
        ctl_nxt.ovf = diff[WIDTH] ^ diff[WIDTH-1];
      end
      // divide seeds {remainder, dividend}
      OP_DIV, OP_MOD: acc_nxt = {{WIDTH{1'b0}}, ma_nxt};
      default: acc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctl_r <= ctl_nxt;
      ma_r  <= ma_nxt;
      mb_r  <= mb_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign valid_o = valid_r;
  assign ctl_o   = ctl_r;
  assign ma_o    = ma_r;
  assign mb_o    = mb_r;
  assign acc_o   = acc_r;

endmodule

// ===== src/sbam_cell.sv =====
// One cell of the row: a shift-add multiply step and a restoring divide step.
`timescale 1ns / 1ps

module sbam_cell import sbam_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH,
  parameter int STEP  = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  ctl_t                 ctl_i,
  input  logic [WIDTH-1:0]     ma_i,
  input  logic [WIDTH-1:0]     mb_i,
  input  logic [2*WIDTH-1:0]   acc_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output ctl_t                 ctl_o,
  output logic [WIDTH-1:0]     ma_o,
  output logic [WIDTH-1:0]     mb_o,
  output logic [2*WIDTH-1:0]   acc_o,
  input  logic                 ready_i
);

  logic               valid_r, valid_nxt;
  logic               take;
  ctl_t               ctl_r;
  logic [WIDTH-1:0]   ma_r, mb_r;
  logic [2*WIDTH-1:0] acc_r, acc_nxt;
  logic [2*WIDTH-1:0] ma_ext;
  logic [WIDTH-1:0]   rem_sh;
  logic [WIDTH:0]     trial;

  assign ready_o   = !valid_r || ready_i;
  assign take      = valid_i && ready_o;
  assign valid_nxt = take || (valid_r && !ready_i);

  always_comb begin
    ma_ext = {{WIDTH{1'b0}}, ma_i};
    // remainder stays below the divisor, so its top bit is always clear
    rem_sh = {acc_i[2*WIDTH-2:WIDTH], acc_i[WIDTH-1]};
    trial  = {1'b0, rem_sh} - {1'b0, mb_i};
    acc_nxt = acc_i;
    if (ctl_i.op == OP_MUL) begin
      if (mb_i[STEP]) begin
        acc_nxt = acc_i + (ma_ext << STEP);
      end
    end else if (ctl_i.op inside {OP_DIV, OP_MOD}) begin
      if (trial[WIDTH]) begin
        acc_nxt = {rem_sh, acc_i[WIDTH-2:0], 1'b0};
      end else begin
        acc_nxt = {trial[WIDTH-1:0], acc_i[WIDTH-2:0], 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctl_r <= ctl_i;
      ma_r  <= ma_i;
      mb_r  <= mb_i;
      acc_r <= acc_nxt;
    end
  end

  assign valid_o = valid_r;
  assign ctl_o   = ctl_r;
  assign ma_o    = ma_r;
  assign mb_o    = mb_r;
  assign acc_o   = acc_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (ctl_r.op == OP_DIV || ctl_r.op == OP_MOD) && (mb_r != '0)
    |-> acc_r[2*WIDTH-1:WIDTH] < mb_r)
    else $error("remainder not below divisor");

endmodule

// ===== src/sbam_post.sv =====
// Output stage: applies signs, flags overflow and zero divisor, holds the result.
`timescale 1ns / 1ps

module sbam_post import sbam_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  ctl_t                 ctl_i,
  input  logic [WIDTH-1:0]     mb_i,
  input  logic [2*WIDTH-1:0]   acc_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output logic [WIDTH-1:0]     result_o,
  output logic                 overflow_o,
  output logic                 dbz_o,
  input  logic                 stall_i
);

  localparam logic [2*WIDTH-1:0] HALF = (2*WIDTH)'(1) << (WIDTH-1);

  logic             valid_r, valid_nxt;
  logic             take;
  logic [WIDTH-1:0] result_r, result_nxt;
  logic             overflow_r, overflow_nxt;
  logic             dbz_r, dbz_nxt;
  logic             neg;
  logic [WIDTH-1:0] lo, hi;

  assign ready_o   = !valid_r || !stall_i;
  assign take      = valid_i && ready_o;
  assign valid_nxt = take || (valid_r && stall_i);

  always_comb begin
    neg = ctl_i.neg_a ^ ctl_i.neg_b;
    lo  = acc_i[WIDTH-1:0];
    hi  = acc_i[2*WIDTH-1:WIDTH];
    result_nxt   = '0;
    overflow_nxt = 1'b0;
    dbz_nxt      = 1'b0;
    case (ctl_i.op)
      OP_ADD, OP_SUB: begin
        result_nxt   = lo;
        overflow_nxt = ctl_i.ovf;
      end
      OP_MUL: begin
        result_nxt   = neg ? -lo : lo;
        // negative side reaches one further than positive
        overflow_nxt = neg ? (acc_i > HALF) : (|acc_i[2*WIDTH-1:WIDTH-1]);
      end
      OP_DIV: begin
        if (mb_i == '0) begin
          dbz_nxt = 1'b1;
        end else begin
          result_nxt   = neg ? -lo : lo;
          overflow_nxt = !neg && lo[WIDTH-1];
        end
      end
      OP_MOD: begin
        if (mb_i == '0) begin
          dbz_nxt = 1'b1;
        end else begin
          result_nxt = ctl_i.neg_a ? -hi : hi;
        end
      end
      default: begin
        result_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r   <= result_nxt;
      overflow_r <= overflow_nxt;
      dbz_r      <= dbz_nxt;
    end
  end

  assign valid_o    = valid_r;
  assign result_o   = result_r;
  assign overflow_o = overflow_r;
  assign dbz_o      = dbz_r;

endmodule

// ===== src/signed_byte_alu_mul_div.sv =====
// Top level: signed ALU with add, subtract, multiply, divide and modulo.
//
// Input channel: in_valid / in_stall with in_func, in_operand_a, in_operand_b.
// A beat is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with out_result, out_overflow and
// out_divide_by_zero; one result beat for every input beat, in order.
// in_func: 0 add, 1 subtract, 2 multiply, 3 divide, 4 modulo; other codes
// give 0 with both flags clear. Results wrap to WIDTH bits.
// The datapath is a front stage, a row of WIDTH cells and an output register.
// Each cell does one bit of the shift-add multiply and one bit of the restoring
// divide.
// Throughput is one beat per cycle while out_stall is low; each stage holds one beat
// and moves on when the next stage is empty or emptying.
// When out_stall is high the output register holds its beat and the row keeps
// filling behind it until every stage is occupied, then in_stall rises.
// Synchronous reset empties every stage; no beat is in flight after reset.
`timescale 1ns / 1ps

module signed_byte_alu_mul_div import sbam_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [WIDTH-1:0]   in_operand_a,
  input  logic [WIDTH-1:0]   in_operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [WIDTH-1:0]   out_result,
  output logic               out_overflow,
  output logic               out_divide_by_zero
);

  // index k feeds cell k; index WIDTH feeds the output stage
  logic               valid_w [0:WIDTH];
  logic               ready_w [0:WIDTH];
  ctl_t               ctl_w   [0:WIDTH];
  logic [WIDTH-1:0]   ma_w    [0:WIDTH];
  logic [WIDTH-1:0]   mb_w    [0:WIDTH];
  logic [2*WIDTH-1:0] acc_w   [0:WIDTH];
  logic               prep_ready;

  assign in_stall = !prep_ready;

  sbam_prep #(.WIDTH(WIDTH)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .func_i  (in_func),
    .a_i     (in_operand_a),
    .b_i     (in_operand_b),
    .ready_o (prep_ready),
    .valid_o (valid_w[0]),
    .ctl_o   (ctl_w[0]),
    .ma_o    (ma_w[0]),
    .mb_o    (mb_w[0]),
    .acc_o   (acc_w[0]),
    .ready_i (ready_w[0])
  );

  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    sbam_cell #(.WIDTH(WIDTH), .STEP(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_w[k]),
      .ctl_i   (ctl_w[k]),
      .ma_i    (ma_w[k]),
      .mb_i    (mb_w[k]),
      .acc_i   (acc_w[k]),
      .ready_o (ready_w[k]),
      .valid_o (valid_w[k+1]),
      .ctl_o   (ctl_w[k+1]),
      .ma_o    (ma_w[k+1]),
      .mb_o    (mb_w[k+1]),
      .acc_o   (acc_w[k+1]),
      .ready_i (ready_w[k+1])
    );
  end

  sbam_post #(.WIDTH(WIDTH)) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (valid_w[WIDTH]),
    .ctl_i      (ctl_w[WIDTH]),
    .mb_i       (mb_w[WIDTH]),
    .acc_i      (acc_w[WIDTH]),
    .ready_o    (ready_w[WIDTH]),
    .valid_o    (out_valid),
    .result_o   (out_result),
    .overflow_o (out_overflow),
    .dbz_o      (out_divide_by_zero),
    .stall_i    (out_stall)
  );

  a_dbz_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> (out_result == '0) && !out_overflow)
    else $error("zero divisor beat with nonzero result or overflow");

  a_empty_front_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_w[0] |-> !in_stall)
    else $error("stall raised with empty front stage");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> valid_w[0])
    else $error("accepted beat lost at front stage");

  a_full_row_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && valid_w[0] && valid_w[WIDTH] |-> !ready_w[WIDTH])
    else $error("output stage took a beat while stalled and full");

endmodule
